>>> rtl/ntc_pkg.sv
// Package for the numeric type converter: type codes, payload structs,
// and the conversion functions used by the back stage.
// No dependencies.
package ntc_pkg;

    typedef enum logic [1:0] {
        TYPE_FP16  = 2'd0,
        TYPE_FP32  = 2'd1,
        TYPE_INT32 = 2'd2,
        TYPE_INT64 = 2'd3
    } num_type_t;

    typedef enum logic [2:0] {
        OP_F32_F16 = 3'd0,
        OP_F16_F32 = 3'd1,
        OP_F32_INT = 3'd2,
        OP_INT_F32 = 3'd3,
        OP_COPY    = 3'd4,
        OP_UNSUP   = 3'd5
    } conv_op_t;

    localparam logic [0:0] CFG_SOURCE_TYPE = 1'b0;
    localparam logic [0:0] CFG_DEST_TYPE   = 1'b1;

    typedef struct packed {
        logic [63:0] element_bits;
        logic        last_in;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        unsupported;
        logic        last_out;
    } out_word_t;

    // front to back: masked operand plus decoded op
    typedef struct packed {
        conv_op_t    op;
        logic        is64;
        logic [63:0] x;
        logic        last;
    } job_t;

    function automatic logic [15:0] f32_to_f16(input logic [31:0] f);
        logic [15:0] s;
        logic [7:0]  e;
        logic [22:0] m;
        logic [15:0] h;
        logic [12:0] rem;
        logic [4:0]  sh;
        logic [24:0] sig;
        logic [24:0] keep;
        logic [24:0] rmask;
        logic [24:0] r;
        logic [24:0] half;
        s = {f[31], 15'd0};
        e = f[30:23];
        m = f[22:0];
        h = '0;
        rem = m[12:0];
        sh = '0;
        sig = '0;
        keep = '0;
        rmask = '0;
        r = '0;
        half = '0;
        if (e == 8'd255)
        begin
            h = (m != 0) ? (s | 16'h7E00 | {6'd0, m[22:13]}) : (s | 16'h7C00);
        end
        else if (e >= 8'd143)
        begin
            h = s | 16'h7C00;
        end
        else if (e >= 8'd113)
        begin
            h = {1'b0, 5'(e - 8'd112), m[22:13]};
            if (rem > 13'h1000 || (rem == 13'h1000 && h[0]))
                h = h + 16'd1;
            h = s | h;
        end
        else if (e == 8'd0 || e < 8'd102)
        begin
            h = s;
        end
        else
        begin
            sh = 5'(8'd126 - e);
            sig = {2'b01, m};
            keep = sig >> sh;
            rmask = (25'd1 << sh) - 25'd1;
            r = sig & rmask;
            half = 25'd1 << (sh - 5'd1);
            if (r > half || (r == half && keep[0]))
                keep = keep + 25'd1;
            h = s | keep[15:0];
        end
        return h;
    endfunction

    function automatic logic [31:0] f16_to_f32(input logic [15:0] hv);
        logic [31:0] o;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  lz;
        logic [10:0] mm;
        e = hv[14:10];
        m = hv[9:0];
        o = {hv[15], 31'd0};
        lz = '0;
        mm = '0;
        if (e == 5'd31)
            o = o | 32'h7F800000 | {9'd0, m, 13'd0} | ((m != 0) ? 32'h400000 : 32'd0);
        else if (e == 5'd0)
        begin
            if (m != 0)
            begin
                for (int i = 0; i < 10; i++)
                    if (m[i])
                        lz = 4'(9 - i);
                mm = {1'b0, m} << (lz + 4'd1);
                o = o | {1'b0, 8'(8'd113 - 8'(lz) - 8'd1), mm[9:0], 13'd0};
            end
        end
        else
            o = o | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
        return o;
    endfunction

endpackage

>>> rtl/numeric_type_converter_unit.sv
// Path: the input word is written into the queue at the accepting edge,
// then passes through the two back stages to the output registers.
// Throughput: one word per cycle; the two-entry queue and back-stage
// registers let either side stall independently.
// Reset: rst_n async active low; source_type resets to fp32, dest_type to fp16.
// Config port always ready; depends on ntc_pkg, ntc_front, ntc_queue, ntc_back.
module numeric_type_converter_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [1:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  ntc_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output ntc_pkg::out_word_t  out_word
);
    logic          fq_valid;
    logic          fq_ready;
    ntc_pkg::job_t fq_job;
    logic          qb_valid;
    logic          qb_ready;
    ntc_pkg::job_t qb_job;

    ntc_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    ntc_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
    );

    ntc_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );
endmodule

>>> rtl/ntc_front.sv
// Front stage: holds config, masks and classifies each input word.
// Depends on ntc_pkg.
module ntc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  ntc_pkg::in_word_t in_word,
    output logic              job_valid,
    input  logic              job_ready,
    output ntc_pkg::job_t     job
);
    logic [1:0] src_reg;
    logic [1:0] dst_reg;
    ntc_pkg::job_t job_next;

    assign cfg_ready = 1'b1;
    assign in_ready = job_ready;
    assign job_valid = in_valid;
    assign job = job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= ntc_pkg::TYPE_FP32;
            dst_reg <= ntc_pkg::TYPE_FP16;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ntc_pkg::CFG_SOURCE_TYPE)
                src_reg <= cfg_data;
            else
                dst_reg <= cfg_data;
        end
    end

    always_comb
    begin
        job_next.last = in_word.last_in;
        job_next.is64 = (dst_reg == ntc_pkg::TYPE_INT64) || (src_reg == ntc_pkg::TYPE_INT64);
        job_next.x = in_word.element_bits;
        case (src_reg)
            ntc_pkg::TYPE_FP16:  job_next.x = {48'd0, in_word.element_bits[15:0]};
            ntc_pkg::TYPE_FP32:  job_next.x = {32'd0, in_word.element_bits[31:0]};
            ntc_pkg::TYPE_INT32: job_next.x = {{32{in_word.element_bits[31]}},
                                               in_word.element_bits[31:0]};
            default:             job_next.x = in_word.element_bits;
        endcase
        if (src_reg == ntc_pkg::TYPE_FP32 && dst_reg == ntc_pkg::TYPE_FP16)
            job_next.op = ntc_pkg::OP_F32_F16;
        else if (src_reg == ntc_pkg::TYPE_FP16 && dst_reg == ntc_pkg::TYPE_FP32)
            job_next.op = ntc_pkg::OP_F16_F32;
        else if (src_reg == ntc_pkg::TYPE_FP32 && dst_reg[1])
            job_next.op = ntc_pkg::OP_F32_INT;
        else if (src_reg[1] && dst_reg == ntc_pkg::TYPE_FP32)
            job_next.op = ntc_pkg::OP_INT_F32;
        else if (src_reg == dst_reg)
            job_next.op = ntc_pkg::OP_COPY;
        else
            job_next.op = ntc_pkg::OP_UNSUP;
    end
endmodule

>>> rtl/ntc_queue.sv
// Two-entry queue between front and back stages.
// Depends on ntc_pkg.
module ntc_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ntc_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ntc_pkg::job_t rd_job
);
    ntc_pkg::job_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_fire;
    logic       rd_fire;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job = mem_reg[rp_reg];
    assign wr_fire = wr_valid && wr_ready;
    assign rd_fire = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_fire)
                wp_reg <= !wp_reg;
            if (rd_fire)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_fire) - 2'(rd_fire);
        end
    end
endmodule

>>> rtl/ntc_back.sv
// Back stage: two-step pipeline (normalize/shift, then round) into output regs.
// Depends on ntc_pkg.
module ntc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  ntc_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output ntc_pkg::out_word_t out_word
);
    typedef struct packed {
        logic        rnd;       // needs int-to-float rounding in stage 2
        logic [31:0] bits;
        logic        inc;
        logic [63:0] res;
        logic        unsup;
        logic        last;
    } conv_res_t;

    // stage 1 and stage 2 registers, and advance enables
    logic        v1_reg;
    conv_res_t   r1_reg;
    logic        v2_reg;
    ntc_pkg::out_word_t o2_reg;
    logic        adv2;
    logic        adv1;

    conv_res_t   r1_next;
    logic        neg;
    logic [63:0] mag;
    logic [5:0]  p;
    logic [5:0]  sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic [7:0]  e;
    logic [63:0] sig;
    logic [63:0] imag;
    logic [63:0] minv;
    logic [5:0]  wm1;

    assign adv2 = !v2_reg || out_ready;
    assign adv1 = !v1_reg || adv2;
    assign job_ready = adv1;
    assign out_valid = v2_reg;
    assign out_word = o2_reg;

    always_comb
    begin
        r1_next = '0;
        r1_next.last = job.last;
        neg = job.x[63];
        mag = neg ? (64'd0 - job.x) : job.x;
        p = '0;
        for (int i = 0; i < 64; i++)
            if (mag[i])
                p = 6'(i);
        sh = '0;
        keep = '0;
        rem = '0;
        half = '0;
        e = job.x[30:23];
        sig = {40'd0, 1'b1, job.x[22:0]};
        imag = '0;
        wm1 = job.is64 ? 6'd63 : 6'd31;
        minv = job.is64 ? 64'h8000000000000000 : 64'h80000000;
        case (job.op)
            ntc_pkg::OP_F32_F16: r1_next.res = {48'd0, ntc_pkg::f32_to_f16(job.x[31:0])};
            ntc_pkg::OP_F16_F32: r1_next.res = {32'd0, ntc_pkg::f16_to_f32(job.x[15:0])};
            ntc_pkg::OP_COPY:    r1_next.res = job.is64 ? job.x
                                             : (job.x & {32'd0, 32'hFFFFFFFF});
            ntc_pkg::OP_UNSUP:   r1_next.unsup = 1'b1;
            ntc_pkg::OP_F32_INT:
            begin
                if (e == 8'd255 && job.x[22:0] != 0)
                    r1_next.res = '0;
                else if (e < 8'd127)
                    r1_next.res = '0;
                else if ({2'd0, 6'(e - 8'd127)} >= {2'd0, wm1} || e >= 8'd191)
                    r1_next.res = job.x[31] ? minv : (minv - 64'd1);
                else
                begin
                    if (e >= 8'd150)
                        imag = sig << 6'(e - 8'd150);
                    else
                        imag = sig >> 6'(8'd150 - e);
                    r1_next.res = job.x[31] ? (64'd0 - imag) : imag;
                    if (!job.is64)
                        r1_next.res[63:32] = '0;
                end
            end
            default:
            begin
                if (mag != 0)
                begin
                    r1_next.rnd = 1'b1;
                    if (p <= 6'd23)
                        r1_next.bits = {neg, 8'({2'd0, p} + 8'd127),
                                        23'(mag << (6'd23 - p))};
                    else
                    begin
                        sh = p - 6'd23;
                        keep = mag >> sh;
                        rem = mag & ((64'd1 << sh) - 64'd1);
                        half = 64'd1 << (sh - 6'd1);
                        r1_next.bits = {neg, 8'({2'd0, p} + 8'd127), keep[22:0]};
                        r1_next.inc = rem > half || (rem == half && keep[0]);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && job_valid)
            r1_reg <= r1_next;
        if (adv2 && v1_reg)
        begin
            o2_reg.last_out <= r1_reg.last;
            o2_reg.unsupported <= r1_reg.unsup;
            if (r1_reg.rnd)
                o2_reg.result_bits <= {32'd0, {1'b0, r1_reg.bits[30:0]} + 32'(r1_reg.inc)
                                       | {r1_reg.bits[31], 31'd0}};
            else
                o2_reg.result_bits <= r1_reg.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= job_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end
endmodule

>>> bench/numeric_type_converter_unit_tb.sv
// Testbench for numeric_type_converter_unit: random and directed conversion words
// checked against a behavioral converter model kept in a scoreboard class.
// Depends on ntc_pkg and the numeric_type_converter_unit RTL.
`timescale 1ns / 1ps

module numeric_type_converter_unit_tb;

    class conv_scoreboard;
        ntc_pkg::num_type_t src_t;
        ntc_pkg::num_type_t dst_t;
        ntc_pkg::out_word_t pending[$];
        int mismatches;

        function new();
            src_t = ntc_pkg::TYPE_FP32;
            dst_t = ntc_pkg::TYPE_FP16;
            mismatches = 0;
        endfunction

        function logic [63:0] f32_to_f16_m(logic [31:0] f);
            logic [15:0] s;
            int unsigned e;
            logic [22:0] m;
            int unsigned sh;
            logic [63:0] sig;
            logic [63:0] keep;
            logic [63:0] rem;
            logic [63:0] half;
            logic [15:0] h;
            s = {f[31], 15'd0};
            e = f[30:23];
            m = f[22:0];
            if (e == 255)
                return (m != 0) ? 64'(s | 16'h7E00 | 16'(m >> 13)) : 64'(s | 16'h7C00);
            if (e >= 113)
            begin
                if (e - 112 >= 31)
                    return 64'(s | 16'h7C00);
                h = 16'(((e - 112) << 10) | (m >> 13));
                if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && h[0]))
                    h = h + 16'd1;
                return 64'(s | h);
            end
            if (e == 0)
                return 64'(s);
            sh = 126 - e;
            if (sh > 24)
                return 64'(s);
            sig = 64'({1'b1, m});
            keep = sig >> sh;
            rem = sig & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0]))
                keep = keep + 64'd1;
            return 64'(s | keep[15:0]);
        endfunction

        function logic [63:0] f16_to_f32_m(logic [15:0] hv);
            logic [31:0] s;
            int unsigned e;
            logic [31:0] m;
            int unsigned e32;
            s = {hv[15], 31'd0};
            e = hv[14:10];
            m = 32'(hv[9:0]);
            if (e == 31)
                return 64'(s | 32'h7F800000 | (m << 13) | ((m != 0) ? 32'h400000 : 32'd0));
            if (e == 0)
            begin
                if (m == 0)
                    return 64'(s);
                e32 = 113;
                while (!m[10])
                begin
                    m = m << 1;
                    e32--;
                end
                return 64'(s | (32'(e32) << 23) | ((m & 32'h3FF) << 13));
            end
            return 64'(s | (32'(e + 112) << 23) | (m << 13));
        endfunction

        function logic [63:0] f32_to_int_m(logic [31:0] f, int unsigned w);
            int unsigned e;
            logic [63:0] minv;
            logic [63:0] mag;
            logic [63:0] sig;
            logic [63:0] mask;
            e = f[30:23];
            mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            minv = 64'd1 << (w - 1);
            if (e == 255 && f[22:0] != 0)
                return 0;
            if (e < 127)
                return 0;
            if (e - 127 >= w - 1)
                return f[31] ? minv : minv - 64'd1;
            sig = 64'({1'b1, f[22:0]});
            if (e - 127 >= 23)
                mag = sig << (e - 150);
            else
                mag = sig >> (150 - e);
            return (f[31] ? (64'd0 - mag) : mag) & mask;
        endfunction

        function logic [63:0] int_to_f32_m(logic [63:0] v);
            logic [31:0] s;
            logic [63:0] mag;
            int p;
            int sh;
            logic [63:0] keep;
            logic [63:0] rem;
            logic [63:0] half;
            logic [31:0] bits;
            s = 0;
            mag = v;
            if (v[63])
            begin
                s = 32'h80000000;
                mag = 64'd0 - v;
            end
            if (mag == 0)
                return 0;
            p = 63;
            while (!mag[p])
                p--;
            if (p <= 23)
                return 64'(s | (32'(p + 127) << 23) | (32'(mag << (23 - p)) & 32'h7FFFFF));
            sh = p - 23;
            keep = mag >> sh;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            bits = (32'(p + 127) << 23) | (32'(keep) & 32'h7FFFFF);
            if (rem > half || (rem == half && keep[0]))
                bits = bits + 32'd1;
            return 64'(s | bits);
        endfunction

        function void note_input(ntc_pkg::in_word_t w);
            ntc_pkg::out_word_t o;
            logic [63:0] x;
            x = w.element_bits;
            if (src_t == ntc_pkg::TYPE_FP16)
                x = x & 64'hFFFF;
            else if (src_t != ntc_pkg::TYPE_INT64)
                x = x & 64'hFFFF_FFFF;
            o.result_bits = 0;
            o.unsupported = 0;
            o.last_out = w.last_in;
            if (src_t == ntc_pkg::TYPE_FP32 && dst_t == ntc_pkg::TYPE_FP16)
                o.result_bits = f32_to_f16_m(x[31:0]);
            else if (src_t == ntc_pkg::TYPE_FP16 && dst_t == ntc_pkg::TYPE_FP32)
                o.result_bits = f16_to_f32_m(x[15:0]);
            else if (src_t == ntc_pkg::TYPE_FP32 && dst_t == ntc_pkg::TYPE_INT32)
                o.result_bits = f32_to_int_m(x[31:0], 32);
            else if (src_t == ntc_pkg::TYPE_INT32 && dst_t == ntc_pkg::TYPE_FP32)
                o.result_bits = int_to_f32_m({{32{x[31]}}, x[31:0]});
            else if (src_t == ntc_pkg::TYPE_FP32 && dst_t == ntc_pkg::TYPE_INT64)
                o.result_bits = f32_to_int_m(x[31:0], 64);
            else if (src_t == ntc_pkg::TYPE_INT64 && dst_t == ntc_pkg::TYPE_FP32)
                o.result_bits = int_to_f32_m(x);
            else if (src_t == dst_t)
                o.result_bits = x;
            else
                o.unsupported = 1;
            pending.push_back(o);
        endfunction

        function void check_result(ntc_pkg::out_word_t got);
            ntc_pkg::out_word_t exp_w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.result_bits !== exp_w.result_bits || got.unsupported !== exp_w.unsupported
                || got.last_out !== exp_w.last_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                             exp_w.result_bits, exp_w.unsupported, exp_w.last_out,
                             got.result_bits, got.unsupported, got.last_out);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    ntc_pkg::in_word_t in_word;
    logic out_valid;
    logic out_ready;
    ntc_pkg::out_word_t out_word;

    conv_scoreboard sb;
    int stall_mode;

    numeric_type_converter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: stall pattern changes over time, with stall-free stretches
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_word);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
        endcase
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [0:0] idx, ntc_pkg::num_type_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == ntc_pkg::CFG_SOURCE_TYPE)
            sb.src_t = v;
        else
            sb.dst_t = v;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_word(logic [63:0] bits, logic last);
        ntc_pkg::in_word_t w;
        w.element_bits = bits;
        w.last_in = last;
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic idle_in(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_elem(ntc_pkg::num_type_t t);
        logic [63:0] v;
        logic [31:0] f;
        v = {$urandom, $urandom};
        f = v[31:0];
        case ($urandom_range(0, 5))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'(97 + $urandom_range(0, 30));
            2: f[30:23] = 8'(110 + $urandom_range(0, 40));
            3: f[30:23] = 8'(120 + $urandom_range(0, 70));
            4: f[30:23] = 8'h00;
            default: ;
        endcase
        if (t == ntc_pkg::TYPE_FP32)
            v[31:0] = f;
        else if (t == ntc_pkg::TYPE_FP16 && $urandom_range(0, 2) == 0)
            v[14:10] = ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
        else if (t == ntc_pkg::TYPE_INT64 && $urandom_range(0, 2) == 0)
            v = v >> $urandom_range(0, 63);
        else if (t == ntc_pkg::TYPE_INT32 && $urandom_range(0, 2) == 0)
            v[31:0] = 32'({{32{v[31]}}, v[31:0]} >> $urandom_range(0, 31));
        return v;
    endfunction

    initial
    begin
        logic [63:0] edge_vals[$];
        int burst;
        sb = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        in_word = '0;
        out_ready = 0;
        stall_mode = 0;
        burst = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        edge_vals = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'h7F80_0000, 64'hFF80_0000, 64'h7FC0_0001,
                      64'h477F_F000, 64'h477F_E000, 64'h3380_0000, 64'h3300_0001,
                      64'h0000_0001, 64'h4F00_0000, 64'hDF00_0000, 64'h3F80_1000,
                      64'h8000_0000, 64'h7C00, 64'hFC01, 64'h03FF, 64'h0001,
                      64'h0000_0000_0100_0001, 64'hFFFF_FFFF_8000_0000};
        foreach (edge_vals[i])
            send_word(edge_vals[i], i[0]);
        idle_in(0);
        drain();

        for (int ph = 0; ph < 16; ph++)
        begin
            write_reg(ntc_pkg::CFG_SOURCE_TYPE, ntc_pkg::num_type_t'(ph / 4));
            write_reg(ntc_pkg::CFG_DEST_TYPE, ntc_pkg::num_type_t'(ph % 4));
            cfg_valid <= 1'b0;
            stall_mode = ph % 4;
            for (int k = 0; k < 8; k++)
                send_word(edge_vals[$urandom_range(0, edge_vals.size() - 1)],
                          1'($urandom_range(0, 1)));
            for (int k = 0; k < 108; k++)
            begin
                if (burst <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        idle_in($urandom_range(1, 6));
                    burst = $urandom_range(1, 20);
                end
                send_word(rand_elem(sb.src_t), 1'($urandom_range(0, 1)));
                burst--;
            end
            if (ph == 7)
            begin
                idle_in(0);
                drain();
            end
            idle_in(0);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
